// ===== rtl/core/ercac_pkg.sv =====
// Shared types and constants for the encoder reply check and angle core.
// No dependencies; imported by every module of the block.
package ercac_pkg;

  // Reply framing codes
  localparam logic [7:0] START_CODE = 8'h01;
  localparam logic [2:0] ADDR_CODE  = 3'd2;
  localparam logic [7:0] END_CODE   = 8'h04;

  // Count ranges for the angle: forward up to 5, backward 6 to 15
  localparam logic [7:0] LAST_FWD_CYCLE  = 8'd5;
  localparam logic [7:0] LAST_BACK_CYCLE = 8'd15;

  // Divide by sixty: q = (m * 2185) >> 17, exact for m below 2560
  localparam int unsigned MINUTE_W    = 12;
  localparam logic [11:0] RECIP_60    = 12'd2185;
  localparam int unsigned RECIP_SHIFT = 17;

  // Configuration port
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    REG_TARGET  = 2'd0,
    REG_LEFT    = 2'd1,
    REG_RIGHT   = 2'd2,
    REG_ENABLES = 2'd3
  } reg_idx_t;

  // Hit vector order: bit0 target, bit1 left limit, bit2 right limit
  typedef logic [2:0] hit_vec_t;

  // Register contents plus one-cycle re-arm strobes from position writes
  typedef struct packed {
    logic [15:0] target_pos;
    logic [15:0] left_pos;
    logic [15:0] right_pos;
    hit_vec_t    enables;
    hit_vec_t    rearm;
  } cfg_t;

endpackage

// ===== rtl/core/ercac_cfg.sv =====
// APB-style register file for the positions and enables of the core.
// Depends on ercac_pkg.
module ercac_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ercac_pkg::ADDR_W-1:0]   paddr,
  input  logic [ercac_pkg::DATA_W-1:0]   pwdata,
  output logic [ercac_pkg::DATA_W-1:0]   prdata,
  output logic                           pready,
  output ercac_pkg::cfg_t                cfg
);
  import ercac_pkg::*;

  logic [15:0] target_pos;
  logic [15:0] left_pos;
  logic [15:0] right_pos;
  hit_vec_t    enables;
  logic        wr_en;
  reg_idx_t    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      target_pos <= '0;
      left_pos   <= '0;
      right_pos  <= '0;
      enables    <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_TARGET:  target_pos <= pwdata[15:0];
        REG_LEFT:    left_pos   <= pwdata[15:0];
        REG_RIGHT:   right_pos  <= pwdata[15:0];
        REG_ENABLES: enables    <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // Read-back mux
  always_comb begin
    case (reg_idx)
      REG_TARGET:  prdata = {16'd0, target_pos};
      REG_LEFT:    prdata = {16'd0, left_pos};
      REG_RIGHT:   prdata = {16'd0, right_pos};
      REG_ENABLES: prdata = {29'd0, enables};
      default:     prdata = '0;
    endcase
  end

  // Register view and re-arm strobes for the core
  always_comb begin
    cfg.target_pos = target_pos;
    cfg.left_pos   = left_pos;
    cfg.right_pos  = right_pos;
    cfg.enables    = enables;
    cfg.rearm      = '0;
    if (wr_en) begin
      case (reg_idx)
        REG_TARGET: cfg.rearm[0] = 1'b1;
        REG_LEFT:   cfg.rearm[1] = 1'b1;
        REG_RIGHT:  cfg.rearm[2] = 1'b1;
        default:    cfg.rearm    = '0;
      endcase
    end
  end

endmodule

// ===== rtl/core/ercac_angle.sv =====
// Turns cycle and turn counts into signed degrees and minutes.
// Depends on ercac_pkg; purely combinational.
module ercac_angle (
  input  logic              [7:0] cycles,
  input  logic              [7:0] turns,
  output logic                    in_range,
  output logic signed       [6:0] degrees,
  output logic signed       [6:0] minutes
);
  import ercac_pkg::*;

  logic                backward;
  logic [3:0]          back_cycles;
  logic [MINUTE_W-1:0] m;
  logic [23:0]         prod;
  logic [6:0]          q;
  logic [MINUTE_W-1:0] q_x60;
  logic [6:0]          r;

  assign backward    = (cycles > LAST_FWD_CYCLE);
  assign in_range    = (cycles <= LAST_BACK_CYCLE);
  assign back_cycles = 4'(LAST_BACK_CYCLE - cycles);

  // Minute count; backward counts run down from the top of cycle 15
  assign m = backward ? {back_cycles, ~turns} : {1'b0, cycles[2:0], turns};

  // Divide by sixty via reciprocal, remainder by shift-and-subtract
  assign prod  = 24'(m) * 24'(RECIP_60);
  assign q     = prod[RECIP_SHIFT +: 7];
  assign q_x60 = (MINUTE_W'(q) << 6) - (MINUTE_W'(q) << 2);
  assign r     = 7'(m - q_x60);

  // Negate both parts for backward counts
  assign degrees = backward ? -$signed(q) : $signed(q);
  assign minutes = backward ? -$signed(r) : $signed(r);

endmodule

// ===== rtl/core/encoder_reply_check_and_angle_core.sv =====
// Top level of the encoder reply check and angle core.
// Depends on ercac_pkg, ercac_cfg and ercac_angle.
//
// Usage:
//   Slave stream (s_*) takes one 8-byte encoder reply per transaction; master
//   stream (m_*) returns one result per reply: framing verdict on m_tuser,
//   stored counts, signed degrees/minutes and three one-shot hit flags.
//   The APB-style port holds target, left and right positions and their
//   enables; writing a position re-arms its hit. pready is always high.
// Timing:
//   A reply is registered in the input stage on acceptance, checked and
//   converted from there, and its result is registered into the result
//   stage on m_* once that stage is free. One transaction per cycle is
//   sustained while m_tready stays high; the state feedback (counts, held
//   angle, fired flags) closes within the one compute stage.
// Reset (rst, synchronous): both stages empty, counts, held angle, fired
//   flags and registers cleared.
// Stall: a result waiting on m_tready holds; one more reply is still taken
//   into the input stage, after which s_tready drops until m_tready returns.
module encoder_reply_check_and_angle_core (
  input  logic                          clk,
  input  logic                          rst,
  // s_tdata: start, address, cycles, turns, sub high, sub low, check, end
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [63:0]                   s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // m_tdata: cycles_now[7:0], turns_now[15:8], degrees[22:16],
  //          minutes[29:23], target_hit[30], left_limit_hit[31],
  //          right_limit_hit[32], zero fill[39:33]
  output logic [39:0]                   m_tdata,
  // m_tuser: reply_valid
  output logic                          m_tuser,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ercac_pkg::ADDR_W-1:0]  paddr,
  input  logic [ercac_pkg::DATA_W-1:0]  pwdata,
  output logic [ercac_pkg::DATA_W-1:0]  prdata,
  output logic                          pready
);
  import ercac_pkg::*;

  cfg_t cfg;

  // Input stage
  logic        in_valid;
  logic [63:0] in_bytes;

  // Stored state
  logic [7:0]        cycle_count;
  logic [7:0]        turn_count;
  logic signed [6:0] held_degrees;
  logic signed [6:0] held_minutes;
  hit_vec_t          fired;
  hit_vec_t          fired_next;

  // Result stage
  logic              out_valid;
  logic              out_reply_valid;
  logic [7:0]        out_cycles;
  logic [7:0]        out_turns;
  logic signed [6:0] out_degrees;
  logic signed [6:0] out_minutes;
  hit_vec_t          out_hits;

  // Compute signals
  logic              adv;
  logic [7:0]        b_start, b_addr, b_cycles, b_turns, b_sub_hi, b_sub_lo;
  logic [7:0]        b_check, b_end;
  logic              reply_ok;
  logic [7:0]        cycles_next;
  logic [7:0]        turns_next;
  logic              ang_in_range;
  logic signed [6:0] ang_degrees;
  logic signed [6:0] ang_minutes;
  logic signed [6:0] degrees_next;
  logic signed [6:0] minutes_next;
  hit_vec_t          pos_match;
  hit_vec_t          hits;

  ercac_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake: input stage advances when the result stage is free
  assign adv      = in_valid & (~out_valid | m_tready);
  assign s_tready = ~in_valid | ~out_valid | m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (adv) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_bytes <= s_tdata;
    end
  end

  // Byte split
  assign b_start  = in_bytes[7:0];
  assign b_addr   = in_bytes[15:8];
  assign b_cycles = in_bytes[23:16];
  assign b_turns  = in_bytes[31:24];
  assign b_sub_hi = in_bytes[39:32];
  assign b_sub_lo = in_bytes[47:40];
  assign b_check  = in_bytes[55:48];
  assign b_end    = in_bytes[63:56];

  // Framing, address and XOR check
  assign reply_ok = (b_start == START_CODE) && (b_addr[2:0] == ADDR_CODE) &&
                    (b_check == (b_addr ^ b_cycles ^ b_turns ^ b_sub_hi ^ b_sub_lo)) &&
                    (b_end == END_CODE);

  assign cycles_next = reply_ok ? b_cycles : cycle_count;
  assign turns_next  = reply_ok ? b_turns  : turn_count;

  ercac_angle u_angle (
    .cycles   (cycles_next),
    .turns    (turns_next),
    .in_range (ang_in_range),
    .degrees  (ang_degrees),
    .minutes  (ang_minutes)
  );

  // Out-of-range counts keep the previous angle
  assign degrees_next = ang_in_range ? ang_degrees : held_degrees;
  assign minutes_next = ang_in_range ? ang_minutes : held_minutes;

  // One-shot position hits
  assign pos_match[0] = (cfg.target_pos == {cycles_next, turns_next});
  assign pos_match[1] = (cfg.left_pos   == {cycles_next, turns_next});
  assign pos_match[2] = (cfg.right_pos  == {cycles_next, turns_next});
  assign hits = reply_ok ? (pos_match & cfg.enables & ~fired) : '0;

  assign fired_next = (fired & ~cfg.rearm) | (adv ? hits : hit_vec_t'(0));

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_count  <= '0;
      turn_count   <= '0;
      held_degrees <= '0;
      held_minutes <= '0;
      fired        <= '0;
    end else begin
      fired <= fired_next;
      if (adv) begin
        cycle_count  <= cycles_next;
        turn_count   <= turns_next;
        held_degrees <= degrees_next;
        held_minutes <= minutes_next;
      end
    end
  end

  // Result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_reply_valid <= reply_ok;
      out_cycles      <= cycles_next;
      out_turns       <= turns_next;
      out_degrees     <= degrees_next;
      out_minutes     <= minutes_next;
      out_hits        <= hits;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_reply_valid;
  assign m_tdata  = {7'd0, out_hits, out_minutes, out_degrees, out_turns, out_cycles};

`ifndef NO_ASSERTIONS
  // A hit is only reported on a well-formed reply
  a_hit_needs_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_hits == '0) || out_reply_valid)
    else $error("hit reported on a rejected reply");

  // A reported target hit leaves its fired flag set
  a_hit_sets_fired: assert property (@(posedge clk) disable iff (rst)
    (adv && hits[0]) |=> fired[0])
    else $error("target hit did not set its fired flag");

  // A rejected reply leaves the stored counts alone
  a_bad_reply_keeps_counts: assert property (@(posedge clk) disable iff (rst)
    (adv && !reply_ok) |=> $stable(cycle_count) && $stable(turn_count))
    else $error("rejected reply changed the stored counts");

  // Degrees stay within the span the counts can reach
  a_degrees_span: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_degrees >= -7'sd42) && (out_degrees <= 7'sd25))
    else $error("degrees out of span");
`endif

endmodule

// ===== tb/encoder_reply_check_and_angle_core_tb.sv =====
// Self-checking testbench for encoder_reply_check_and_angle_core.
// Uses ercac_pkg; drives replies on s_*, checks m_* against a local predictor.
// Directed rows come first, then randomised replies, with APB register phases.
`timescale 1ns / 100ps

module encoder_reply_check_and_angle_core_tb;
  import ercac_pkg::*;

  // One encoder reply, start byte in the lowest bits of s_tdata
  typedef struct packed {
    logic [7:0] end_byte;
    logic [7:0] check_byte;
    logic [7:0] sub_low_byte;
    logic [7:0] sub_high_byte;
    logic [7:0] turns_byte;
    logic [7:0] cycles_byte;
    logic [7:0] address_byte;
    logic [7:0] start_byte;
  } reply_t;

  // One angle result; hits bit0 target, bit1 left limit, bit2 right limit
  typedef struct packed {
    logic       reply_ok;
    logic [2:0] hits;
    logic [6:0] minutes;
    logic [6:0] degrees;
    logic [7:0] turns;
    logic [7:0] cycles;
  } angle_res_t;

  typedef enum logic {ROW_REPLY, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    reply_t      reply;
    logic        typed;
    angle_res_t  want;
    reg_idx_t    idx;
    logic [31:0] value;
  } plan_row_t;

  localparam int RANDOM_REPLIES = 1850;
  localparam int PHASE_LEN      = 150;

  logic              clk;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [63:0]       s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [39:0]       m_tdata;
  logic              m_tuser;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  encoder_reply_check_and_angle_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Predictor state: register copies, stored counts, held angle, fired flags
  logic [15:0] mark_pos [3];
  logic [2:0]  mark_en;
  logic [2:0]  mark_fired;
  logic [7:0]  held_cycles;
  logic [7:0]  held_turns;
  logic [6:0]  held_deg;
  logic [6:0]  held_min;

  angle_res_t angle_q [$];
  plan_row_t  plan_q [$];

  int  fail_count = 0;
  int  results_seen = 0;
  int  good_replies = 0;
  int  hit_count = 0;
  int  reg_writes = 0;
  bit  tx_burst = 1'b0;
  bit  rx_burst = 1'b0;

  // Clock, 20 ns period
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic void report(string msg);
    fail_count++;
    if (fail_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  function automatic string show(angle_res_t r);
    return $sformatf("ok=%0b cyc=%0d turns=%0d deg=%0d min=%0d hits=%03b", r.reply_ok,
                     r.cycles, r.turns, $signed(r.degrees), $signed(r.minutes), r.hits);
  endfunction

  // Reply with correct framing and check byte
  function automatic reply_t wellformed(logic [7:0] cyc, logic [7:0] trn, logic [7:0] sub_hi,
                                        logic [7:0] sub_lo, logic [4:0] addr_hi);
    reply_t r;
    r.start_byte    = START_CODE;
    r.address_byte  = {addr_hi, ADDR_CODE};
    r.cycles_byte   = cyc;
    r.turns_byte    = trn;
    r.sub_high_byte = sub_hi;
    r.sub_low_byte  = sub_lo;
    r.check_byte    = r.address_byte ^ cyc ^ trn ^ sub_hi ^ sub_lo;
    r.end_byte      = END_CODE;
    return r;
  endfunction

  function automatic angle_res_t outcome(bit ok, int cyc, int trn, int deg, int mins,
                                         bit [2:0] hits);
    angle_res_t r;
    r.reply_ok = ok;
    r.cycles   = 8'(cyc);
    r.turns    = 8'(trn);
    r.degrees  = 7'(deg);
    r.minutes  = 7'(mins);
    r.hits     = hits;
    return r;
  endfunction

  // Framing check, count update, angle conversion and one-shot hits
  function automatic angle_res_t decode_reply(reply_t r);
    angle_res_t res;
    bit         ok;
    int         m;
    ok = (r.start_byte == START_CODE) && (r.address_byte[2:0] == ADDR_CODE) &&
         (r.end_byte == END_CODE) &&
         (r.check_byte == (r.address_byte ^ r.cycles_byte ^ r.turns_byte ^
                           r.sub_high_byte ^ r.sub_low_byte));
    if (ok) begin
      held_cycles = r.cycles_byte;
      held_turns  = r.turns_byte;
      good_replies++;
    end
    if (held_cycles <= LAST_FWD_CYCLE) begin
      m = held_cycles * 256 + held_turns;
      held_deg = 7'(m / 60);
      held_min = 7'(m % 60);
    end else if (held_cycles <= LAST_BACK_CYCLE) begin
      // backward range counts down from the top of cycle 15, negated
      m = (LAST_BACK_CYCLE - held_cycles) * 256 + (255 - held_turns);
      held_deg = 7'(-(m / 60));
      held_min = 7'(-(m % 60));
    end
    res = outcome(ok, held_cycles, held_turns, 0, 0, 3'b000);
    res.degrees = held_deg;
    res.minutes = held_min;
    if (ok) begin
      for (int i = 0; i < 3; i++) begin
        if (mark_en[i] && !mark_fired[i] && mark_pos[i] == {held_cycles, held_turns}) begin
          mark_fired[i] = 1'b1;
          res.hits[i]   = 1'b1;
          hit_count++;
        end
      end
    end
    return res;
  endfunction

  function automatic void add_reply(reply_t r);
    plan_row_t row;
    row       = '0;
    row.kind  = ROW_REPLY;
    row.reply = r;
    plan_q.push_back(row);
  endfunction

  function automatic void add_typed(reply_t r, angle_res_t want);
    plan_row_t row;
    row       = '0;
    row.kind  = ROW_REPLY;
    row.reply = r;
    row.typed = 1'b1;
    row.want  = want;
    plan_q.push_back(row);
  endfunction

  function automatic void add_write(reg_idx_t idx, logic [31:0] value);
    plan_row_t row;
    row       = '0;
    row.kind  = ROW_WRITE;
    row.idx   = idx;
    row.value = value;
    plan_q.push_back(row);
  endfunction

  // Mostly well-formed replies, some aimed at the positions, some broken
  function automatic reply_t random_reply();
    reply_t      r;
    int          pick;
    logic [15:0] p;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      r = wellformed(8'($urandom_range(0, 15)), 8'($urandom), 8'($urandom), 8'($urandom),
                     5'($urandom));
    end else if (pick < 8) begin
      p = mark_pos[$urandom_range(0, 2)];
      r = wellformed(p[15:8], p[7:0], 8'($urandom), 8'($urandom), 5'($urandom));
    end else begin
      r = wellformed(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 5'($urandom));
    end
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 4))
        0: r.start_byte = 8'($urandom);
        1: r.address_byte[2:0] = 3'($urandom);
        2: r.check_byte = r.check_byte ^ 8'($urandom_range(1, 255));
        3: r.end_byte = 8'($urandom);
        default: r = {$urandom, $urandom};
      endcase
    end
    return r;
  endfunction

  // Send one reply after a random gap (none in a burst); predict at the accepting edge
  task automatic send_reply(reply_t r, bit typed, angle_res_t want);
    int         gap;
    angle_res_t pred;
    gap = tx_burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tdata  = r;
    s_tvalid = 1'b1;
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    pred = decode_reply(r);
    angle_q.push_back(typed ? want : pred);
  endtask

  // Hold off the sender until every outstanding result has come back
  task automatic drain_results();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (angle_q.size() > 0) @(posedge clk);
  endtask

  // APB write then read-back; updates the predictor's register copies and re-arms a written position
  task automatic apb_write(reg_idx_t idx, logic [31:0] value);
    logic [31:0] stored;
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    if (idx == REG_ENABLES) begin
      mark_en = value[2:0];
      stored  = {29'd0, value[2:0]};
    end else begin
      mark_pos[idx]   = value[15:0];
      mark_fired[idx] = 1'b0;
      stored          = {16'd0, value[15:0]};
    end
    reg_writes++;
    // read-back
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    if (prdata !== stored)
      report($sformatf("register %s read %h, expected %h", idx.name(), prdata, stored));
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Result side: random stalls (none in a burst), compare with the oldest expectation
  initial begin : result_sink
    int         stall;
    angle_res_t got;
    angle_res_t want;
    wait (rst == 1'b0);
    forever begin
      stall = rx_burst ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        @(negedge clk);
        m_tready = 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      m_tready = 1'b1;
      @(posedge clk);
      while (m_tvalid !== 1'b1) @(posedge clk);
      got.reply_ok = m_tuser;
      got.cycles   = m_tdata[7:0];
      got.turns    = m_tdata[15:8];
      got.degrees  = m_tdata[22:16];
      got.minutes  = m_tdata[29:23];
      got.hits     = m_tdata[32:30];
      results_seen++;
      if (angle_q.size() == 0) begin
        report($sformatf("result with nothing outstanding: %s", show(got)));
      end else begin
        want = angle_q.pop_front();
        if (got !== want)
          report($sformatf("result %0d: expected %s, got %s", results_seen, show(want),
                           show(got)));
      end
    end
  end

  initial begin : stimulus
    reply_t    r;
    plan_row_t row;
    int        waited;

    mark_pos    = '{16'd0, 16'd0, 16'd0};
    mark_en     = '0;
    mark_fired  = '0;
    held_cycles = '0;
    held_turns  = '0;
    held_deg    = '0;
    held_min    = '0;

    // Directed rows at reset configuration: framing, angle extremes, hold
    add_typed(wellformed(8'd0, 8'd0, 8'h00, 8'h00, 5'd0), outcome(1, 0, 0, 0, 0, 3'b000));
    r = wellformed(8'd0, 8'd0, 8'h12, 8'h34, 5'd0);
    r.start_byte = 8'h00;
    add_typed(r, outcome(0, 0, 0, 0, 0, 3'b000));
    add_typed(wellformed(8'd5, 8'd255, 8'h55, 8'hAA, 5'd3), outcome(1, 5, 255, 25, 35, 3'b000));
    add_typed(wellformed(8'd6, 8'd0, 8'h00, 8'hFF, 5'd1),
              outcome(1, 6, 0, -42, -39, 3'b000));
    add_reply(wellformed(8'd15, 8'd255, 8'h80, 8'h01, 5'd16));
    add_typed(wellformed(8'd15, 8'd0, 8'h00, 8'h00, 5'd0), outcome(1, 15, 0, -4, -15, 3'b000));
    // cycle count above fifteen keeps the held angle
    add_typed(wellformed(8'd16, 8'd3, 8'h00, 8'h00, 5'd0), outcome(1, 16, 3, -4, -15, 3'b000));
    add_reply(wellformed(8'd255, 8'd255, 8'hFF, 8'hFF, 5'h1F));
    r = wellformed(8'd1, 8'd1, 8'h00, 8'h00, 5'd0);
    r.address_byte = 8'h03;
    add_typed(r, outcome(0, 255, 255, -4, -15, 3'b000));
    r = wellformed(8'd2, 8'd2, 8'h00, 8'h00, 5'h1F);
    r.end_byte = 8'h05;
    add_reply(r);
    r = wellformed(8'd3, 8'd3, 8'h00, 8'h00, 5'd0);
    r.check_byte = r.check_byte ^ 8'h80;
    add_reply(r);
    add_reply(64'hFFFF_FFFF_FFFF_FFFF);

    // Positions armed; extra upper bits of the target write are dropped
    add_write(REG_TARGET, 32'hFFFF_0102);
    add_write(REG_LEFT, 32'h0000_0000);
    add_write(REG_RIGHT, 32'h0000_FFFF);
    add_write(REG_ENABLES, 32'h0000_0007);
    add_typed(wellformed(8'd1, 8'd2, 8'h00, 8'h00, 5'd0), outcome(1, 1, 2, 4, 18, 3'b001));
    add_reply(wellformed(8'd1, 8'd2, 8'h00, 8'h00, 5'd0));
    r = wellformed(8'd0, 8'd0, 8'h00, 8'h00, 5'd0);
    r.check_byte = 8'hFF;
    add_reply(r);
    add_typed(wellformed(8'd0, 8'd0, 8'h00, 8'h00, 5'd0), outcome(1, 0, 0, 0, 0, 3'b010));
    add_typed(wellformed(8'd255, 8'd255, 8'h00, 8'h00, 5'd0),
              outcome(1, 255, 255, 0, 0, 3'b100));
    // re-arm the target, disable the right limit
    add_write(REG_TARGET, 32'h0000_0102);
    add_write(REG_ENABLES, 32'h0000_0003);
    add_reply(wellformed(8'd1, 8'd2, 8'h00, 8'h00, 5'd0));
    add_reply(wellformed(8'd255, 8'd255, 8'h00, 8'h00, 5'd0));
    // enables write alone must not re-arm
    add_write(REG_ENABLES, 32'h0000_0007);
    add_reply(wellformed(8'd1, 8'd2, 8'h00, 8'h00, 5'd0));
    add_write(REG_RIGHT, 32'h0000_FFFF);
    add_write(REG_ENABLES, 32'h0000_0000);
    add_reply(wellformed(8'd255, 8'd255, 8'h00, 8'h00, 5'd0));
    add_write(REG_ENABLES, 32'h0000_0004);
    add_reply(wellformed(8'd255, 8'd255, 8'h00, 8'h00, 5'd0));

    // Hold reset, then release it on a falling edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Walk the directed table
    foreach (plan_q[i]) begin
      row = plan_q[i];
      if (row.kind == ROW_WRITE) begin
        drain_results();
        apb_write(row.idx, row.value);
      end else begin
        send_reply(row.reply, row.typed, row.want);
      end
    end

    // Random phases, each opened with an idle register update
    for (int n = 0; n < RANDOM_REPLIES; n++) begin
      if (n % PHASE_LEN == 0) begin
        drain_results();
        for (int k = 0; k < 3; k++) begin
          if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 4))
              0: apb_write(reg_idx_t'(k), {16'($urandom), 16'h0000});
              1: apb_write(reg_idx_t'(k), {16'($urandom), 16'hFFFF});
              2: apb_write(reg_idx_t'(k), {16'($urandom), 8'($urandom_range(0, 17)),
                                           8'($urandom)});
              default: apb_write(reg_idx_t'(k), $urandom);
            endcase
          end
        end
        case ($urandom_range(0, 3))
          0: apb_write(REG_ENABLES, {29'($urandom), 3'b111});
          1: apb_write(REG_ENABLES, {29'($urandom), 3'b000});
          default: apb_write(REG_ENABLES, $urandom);
        endcase
        tx_burst = ($urandom_range(0, 3) == 0);
        rx_burst = ($urandom_range(0, 3) == 0);
      end
      send_reply(random_reply(), 1'b0, '0);
    end

    // Wait for the tail, then stay idle to catch stray results
    @(negedge clk);
    s_tvalid = 1'b0;
    waited = 0;
    while (angle_q.size() > 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    if (angle_q.size() > 0)
      report($sformatf("%0d results never arrived", angle_q.size()));
    repeat (10) @(posedge clk);

    $display("Run covered %0d replies, %0d well framed, %0d position hits, %0d register writes.",
             results_seen, good_replies, hit_count, reg_writes);
    $display("Mismatches and protocol errors: %0d", fail_count);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/ercac_pkg.sv
rtl/core/ercac_cfg.sv
rtl/core/ercac_angle.sv
rtl/core/encoder_reply_check_and_angle_core.sv
tb/encoder_reply_check_and_angle_core_tb.sv
